/* rtl/i2c_master_bit_engine_top_macros.svh */
// Assertion macros shared by the I2C master bit engine RTL.
// Define ASSERT_OFF to compile every check away.
`ifndef I2C_MASTER_BIT_ENGINE_TOP_MACROS_SVH
`define I2C_MASTER_BIT_ENGINE_TOP_MACROS_SVH

`ifndef ASSERT_OFF
`define I2CMB_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define I2CMB_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define I2CMB_ASSERT(lbl, clk, rst_n, prop, msg)
`define I2CMB_NEVER(lbl, clk, rst_n, cond, msg)
`endif

`endif

/* rtl/i2cmb_pkg.sv */
// Shared types and constants of the I2C master bit engine.
// No dependencies; used by the front, back and top-level modules.
`default_nettype none
package i2cmb_pkg;

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_STOP  = 2'd1,
    CMD_WRITE = 2'd2,
    CMD_READ  = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t       cmd;
    logic [7:0] data;
    logic       ack;
  } desc_t;

  localparam int Q_DEPTH = 2;
  localparam int QPTR_W  = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

  localparam int STEP_W = 5;
  typedef logic [STEP_W-1:0] step_t;

  localparam step_t LAST_START  = 5'd1;
  localparam step_t LAST_STOP   = 5'd2;
  localparam step_t LAST_WRITE  = 5'd26;
  localparam step_t RD_ACK_SET  = 5'd17;
  localparam step_t RD_ACK_HI   = 5'd18;
  localparam step_t RD_ACK_LO   = 5'd19;
  localparam step_t LAST_READ   = 5'd20;

  localparam step_t STOP_SCL_HI = 5'd1;

endpackage
`default_nettype wire

/* rtl/i2cmb_front.sv */
// Front end: accepts command beats, classifies them into descriptors
// and queues them for the back end. Depends on i2cmb_pkg.
`default_nettype none
`include "i2c_master_bit_engine_top_macros.svh"
module i2cmb_front (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire logic [1:0]      in_cmd,
  input  wire logic [7:0]      in_write_byte,
  input  wire logic            in_send_ack,
  input  wire logic [7:0]      in_slave_bits,
  output logic                 q_valid,
  output i2cmb_pkg::desc_t     q_desc,
  input  wire logic            q_pop
);
  import i2cmb_pkg::*;

  desc_t              q_r [Q_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]  cnt_r, cnt_nxt;
  desc_t              new_desc;
  logic               push;
  logic               pop;

  always_comb begin
    new_desc.cmd  = cmd_t'(in_cmd);
    new_desc.ack  = 1'b0;
    new_desc.data = 8'd0;
    unique case (cmd_t'(in_cmd))
      CMD_WRITE: new_desc.data = in_write_byte;
      CMD_READ: begin
        new_desc.data = in_slave_bits;
        new_desc.ack  = in_send_ack;
      end
      default: ;
    endcase
  end

  assign in_stall = (cnt_r == QCNT_W'(Q_DEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != '0);
  assign pop      = q_pop && q_valid;
  assign q_desc   = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= new_desc;
    end
  end

  `I2CMB_ASSERT(a_cnt_bound, clk, rst_n, cnt_r <= QCNT_W'(Q_DEPTH), "queue count overflow")
  `I2CMB_ASSERT(a_empty_ptrs, clk, rst_n, (cnt_r == '0) |-> (wr_ptr_r == rd_ptr_r), "empty queue pointers differ")
  `I2CMB_ASSERT(a_full_ptrs, clk, rst_n, (cnt_r == QCNT_W'(Q_DEPTH)) |-> (wr_ptr_r == rd_ptr_r), "full queue pointers differ")

endmodule
`default_nettype wire

/* rtl/i2cmb_back.sv */
// Back end: steps through one queued command, one line snapshot a cycle when
// not stalled, held in the output register. Depends on i2cmb_pkg.
`default_nettype none
`include "i2c_master_bit_engine_top_macros.svh"
module i2cmb_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            q_valid,
  input  wire i2cmb_pkg::desc_t q_desc,
  output logic                 q_pop,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output logic                 out_scl_level,
  output logic                 out_sda_level,
  output logic [7:0]           out_read_data,
  output logic                 out_last
);
  import i2cmb_pkg::*;

  localparam logic [1:0] PH_SET = 2'd0;
  localparam logic [1:0] PH_HI  = 2'd1;
  localparam logic [1:0] PH_LO  = 2'd2;

  logic       busy_r, busy_nxt;
  cmd_t       cmd_r, cmd_nxt;
  logic [7:0] sh_r, sh_nxt;
  logic       ack_r, ack_nxt;
  step_t      step_r, step_nxt;
  logic [1:0] phase_r, phase_nxt;
  logic       scl_r, scl_nxt;
  logic       sda_r, sda_nxt;
  logic       ov_r, ov_nxt;
  logic       oscl_r, oscl_nxt;
  logic       osda_r, osda_nxt;
  logic [7:0] odata_r, odata_nxt;
  logic       olast_r, olast_nxt;

  logic       advance;
  logic       snap_scl, snap_sda, snap_last;
  logic [7:0] snap_data;
  logic       load;

  assign advance = !ov_r || !out_stall;

  always_comb begin
    snap_scl  = scl_r;
    snap_sda  = sda_r;
    snap_last = 1'b0;
    snap_data = 8'd0;
    unique case (cmd_r)
      CMD_START: begin
        if (step_r == '0) begin
          snap_sda = 1'b0;
        end else begin
          snap_scl  = 1'b0;
          snap_last = 1'b1;
        end
      end
      CMD_STOP: begin
        if (step_r == '0) begin
          snap_sda = 1'b0;
        end else if (step_r == STOP_SCL_HI) begin
          snap_scl = 1'b1;
        end else begin
          snap_sda  = 1'b1;
          snap_last = 1'b1;
        end
      end
      CMD_WRITE: begin
        unique case (phase_r)
          PH_SET:  snap_sda = sh_r[7];
          PH_HI:   snap_scl = 1'b1;
          default: snap_scl = 1'b0;
        endcase
        snap_last = (step_r == LAST_WRITE);
      end
      CMD_READ: begin
        if (step_r == '0) begin
          snap_sda = 1'b1;
        end else if (step_r < RD_ACK_SET) begin
          snap_scl = step_r[0];
        end else if (step_r == RD_ACK_SET) begin
          snap_sda = ~ack_r;
        end else if (step_r == RD_ACK_HI) begin
          snap_scl = 1'b1;
        end else if (step_r == RD_ACK_LO) begin
          snap_scl = 1'b0;
        end else begin
          snap_sda  = 1'b1;
          snap_last = 1'b1;
          snap_data = sh_r;
        end
      end
      default: ;
    endcase
  end

  assign load  = advance && q_valid && (!busy_r || snap_last);
  assign q_pop = load;

  always_comb begin
    busy_nxt  = busy_r;
    cmd_nxt   = cmd_r;
    sh_nxt    = sh_r;
    ack_nxt   = ack_r;
    step_nxt  = step_r;
    phase_nxt = phase_r;
    scl_nxt   = scl_r;
    sda_nxt   = sda_r;
    ov_nxt    = ov_r;
    oscl_nxt  = oscl_r;
    osda_nxt  = osda_r;
    odata_nxt = odata_r;
    olast_nxt = olast_r;
    if (advance) begin
      ov_nxt = busy_r;
      if (busy_r) begin
        oscl_nxt  = snap_scl;
        osda_nxt  = snap_sda;
        odata_nxt = snap_data;
        olast_nxt = snap_last;
        scl_nxt   = snap_scl;
        sda_nxt   = snap_sda;
        step_nxt  = step_r + 1'b1;
        if (phase_r == PH_LO) begin
          phase_nxt = PH_SET;
          if (cmd_r == CMD_WRITE) begin
            sh_nxt = {sh_r[6:0], 1'b1};
          end
        end else begin
          phase_nxt = phase_r + 1'b1;
        end
        if (snap_last) begin
          busy_nxt = 1'b0;
        end
      end
      if (load) begin
        busy_nxt  = 1'b1;
        cmd_nxt   = q_desc.cmd;
        sh_nxt    = q_desc.data;
        ack_nxt   = q_desc.ack;
        step_nxt  = '0;
        phase_nxt = PH_SET;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      step_r  <= '0;
      phase_r <= PH_SET;
      scl_r   <= 1'b1;
      sda_r   <= 1'b1;
      ov_r    <= 1'b0;
    end else begin
      busy_r  <= busy_nxt;
      step_r  <= step_nxt;
      phase_r <= phase_nxt;
      scl_r   <= scl_nxt;
      sda_r   <= sda_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r   <= cmd_nxt;
    sh_r    <= sh_nxt;
    ack_r   <= ack_nxt;
    oscl_r  <= oscl_nxt;
    osda_r  <= osda_nxt;
    odata_r <= odata_nxt;
    olast_r <= olast_nxt;
  end

  assign out_valid     = ov_r;
  assign out_scl_level = oscl_r;
  assign out_sda_level = osda_r;
  assign out_read_data = odata_r;
  assign out_last      = olast_r;

  `I2CMB_NEVER(a_phase_code, clk, rst_n, phase_r == 2'd3, "write phase out of range")
  `I2CMB_ASSERT(a_step_bound, clk, rst_n, busy_r |-> (step_r <= LAST_WRITE), "step past end of run")
  `I2CMB_ASSERT(a_data_last, clk, rst_n, (ov_r && !olast_r) |-> (odata_r == 8'd0), "read data outside last beat")
  `I2CMB_ASSERT(a_line_track, clk, rst_n, ov_r |-> (oscl_r == scl_r && osda_r == sda_r), "line state and snapshot differ")

endmodule
`default_nettype wire

/* rtl/i2c_master_bit_engine_top.sv */
// Top level of the I2C master bit engine: front end queue plus back-end
// snapshot sequencer. Depends on i2cmb_pkg, i2cmb_front and i2cmb_back.
//
// Each command beat becomes a run of SCL/SDA snapshot beats from the
// back-end sequencer, one per cycle unless out_stall holds it: start 2,
// stop 3, read 21, write 27 beats. A two-entry command queue in front takes
// new commands while the current run plays out; runs follow with no gap.
// From idle, a command passes the queue entry and back-end registers before
// its first snapshot. Line levels persist across commands and reset to
// released; read_data is the received byte on a read's last beat, else zero.
`default_nettype none
module i2c_master_bit_engine_top (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [1:0] in_cmd,
  input  wire logic [7:0] in_write_byte,
  input  wire logic       in_send_ack,
  input  wire logic [7:0] in_slave_bits,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic            out_scl_level,
  output logic            out_sda_level,
  output logic [7:0]      out_read_data,
  output logic            out_last
);
  import i2cmb_pkg::*;

  logic  q_valid;
  desc_t q_desc;
  logic  q_pop;

  i2cmb_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_cmd        (in_cmd),
    .in_write_byte (in_write_byte),
    .in_send_ack   (in_send_ack),
    .in_slave_bits (in_slave_bits),
    .q_valid       (q_valid),
    .q_desc        (q_desc),
    .q_pop         (q_pop)
  );

  i2cmb_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_valid       (q_valid),
    .q_desc        (q_desc),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_scl_level (out_scl_level),
    .out_sda_level (out_sda_level),
    .out_read_data (out_read_data),
    .out_last      (out_last)
  );

endmodule
`default_nettype wire

/* tb/i2c_master_bit_engine_top_tb.sv */
// Self-checking bench for i2c_master_bit_engine_top: directed table then random I2C traffic.
// Predicts every SCL/SDA beat from tracked line state and typed rows; depends on i2cmb_pkg.
`default_nettype none
module i2c_master_bit_engine_top_tb;
  import i2cmb_pkg::*;

  localparam int RAND_ITEMS = 92;
  localparam int CYCLE_LIMIT = 400000;
  localparam int TAIL_CYCLES = 40;
  localparam int MAX_PRINTS = 40;

  typedef struct {
    logic       scl;
    logic       sda;
    logic [7:0] rd;
    logic       fin;
  } snap_t;

  typedef struct {
    cmd_t       cmd;
    logic [7:0] wb;
    logic       ack;
    logic [7:0] sb;
    bit         typed;
    logic       scl;
    logic       sda;
    logic [7:0] rd;
  } row_t;

  localparam int DIR_N = 18;
  row_t dir_rows [DIR_N] = '{
    '{CMD_START, 8'h00, 1'b0, 8'h00, 1'b1, 1'b0, 1'b0, 8'h00},
    '{CMD_WRITE, 8'h00, 1'b0, 8'h00, 1'b1, 1'b0, 1'b1, 8'h00},
    '{CMD_WRITE, 8'hff, 1'b0, 8'h00, 1'b1, 1'b0, 1'b1, 8'h00},
    '{CMD_WRITE, 8'ha5, 1'b1, 8'hff, 1'b0, 1'b0, 1'b0, 8'h00},
    '{CMD_READ,  8'h00, 1'b1, 8'hff, 1'b1, 1'b0, 1'b1, 8'hff},
    '{CMD_READ,  8'h00, 1'b0, 8'h00, 1'b1, 1'b0, 1'b1, 8'h00},
    '{CMD_READ,  8'hff, 1'b1, 8'ha5, 1'b0, 1'b0, 1'b0, 8'h00},
    '{CMD_READ,  8'h00, 1'b0, 8'h5a, 1'b0, 1'b0, 1'b0, 8'h00},
    '{CMD_WRITE, 8'h5a, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 8'h00},
    '{CMD_STOP,  8'hff, 1'b1, 8'hff, 1'b1, 1'b1, 1'b1, 8'h00},
    '{CMD_STOP,  8'h00, 1'b0, 8'h00, 1'b1, 1'b1, 1'b1, 8'h00},
    '{CMD_WRITE, 8'h80, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 8'h00},
    '{CMD_READ,  8'h00, 1'b1, 8'h01, 1'b0, 1'b0, 1'b0, 8'h00},
    '{CMD_START, 8'hff, 1'b1, 8'hff, 1'b1, 1'b0, 1'b0, 8'h00},
    '{CMD_START, 8'h00, 1'b0, 8'h00, 1'b1, 1'b0, 1'b0, 8'h00},
    '{CMD_WRITE, 8'h01, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 8'h00},
    '{CMD_READ,  8'h00, 1'b1, 8'h80, 1'b0, 1'b0, 1'b0, 8'h00},
    '{CMD_STOP,  8'h00, 1'b0, 8'h00, 1'b1, 1'b1, 1'b1, 8'h00}
  };

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [1:0] in_cmd;
  logic [7:0] in_write_byte;
  logic       in_send_ack;
  logic [7:0] in_slave_bits;
  logic       out_valid;
  logic       out_stall;
  logic       out_scl_level;
  logic       out_sda_level;
  logic [7:0] out_read_data;
  logic       out_last;

  logic       bus_scl;
  logic       bus_sda;
  snap_t      pending_snaps [$];
  snap_t      want;
  bit         calm;
  int         cmds_sent;
  int         fails = 0;
  int         cycles = 0;

  i2c_master_bit_engine_top dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_cmd        (in_cmd),
    .in_write_byte (in_write_byte),
    .in_send_ack   (in_send_ack),
    .in_slave_bits (in_slave_bits),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_scl_level (out_scl_level),
    .out_sda_level (out_sda_level),
    .out_read_data (out_read_data),
    .out_last      (out_last)
  );

  always #5 clk = ~clk;

  task automatic push_snap(input logic [7:0] rd, input logic fin);
    snap_t s;
    s.scl = bus_scl;
    s.sda = bus_sda;
    s.rd  = rd;
    s.fin = fin;
    pending_snaps.push_back(s);
  endtask

  task automatic predict_line_run(input cmd_t c, input logic [7:0] wb, input logic ack,
                                  input logic [7:0] sb);
    case (c)
      CMD_START: begin
        bus_sda = 1'b0; push_snap(8'h00, 1'b0);
        bus_scl = 1'b0; push_snap(8'h00, 1'b1);
      end
      CMD_STOP: begin
        bus_sda = 1'b0; push_snap(8'h00, 1'b0);
        bus_scl = 1'b1; push_snap(8'h00, 1'b0);
        bus_sda = 1'b1; push_snap(8'h00, 1'b1);
      end
      CMD_WRITE: begin
        for (int i = 7; i >= 0; i--) begin
          bus_sda = wb[i]; push_snap(8'h00, 1'b0);
          bus_scl = 1'b1;  push_snap(8'h00, 1'b0);
          bus_scl = 1'b0;  push_snap(8'h00, 1'b0);
        end
        bus_sda = 1'b1; push_snap(8'h00, 1'b0);
        bus_scl = 1'b1; push_snap(8'h00, 1'b0);
        bus_scl = 1'b0; push_snap(8'h00, 1'b1);
      end
      default: begin
        bus_sda = 1'b1; push_snap(8'h00, 1'b0);
        for (int i = 0; i < 8; i++) begin
          bus_scl = 1'b1; push_snap(8'h00, 1'b0);
          bus_scl = 1'b0; push_snap(8'h00, 1'b0);
        end
        if (ack) begin
          bus_sda = 1'b0;
        end
        push_snap(8'h00, 1'b0);
        bus_scl = 1'b1; push_snap(8'h00, 1'b0);
        bus_scl = 1'b0; push_snap(8'h00, 1'b0);
        bus_sda = 1'b1; push_snap(sb, 1'b1);
      end
    endcase
  endtask

  task automatic report_mismatch(input string what, input int got, input int exp_val);
    fails++;
    if (fails <= MAX_PRINTS) begin
      $display("mismatch at cycle %0d: %s got %0h exp %0h", cycles, what, got, exp_val);
    end
  endtask

  task automatic send_cmd(input cmd_t c, input logic [7:0] wb, input logic ack,
                          input logic [7:0] sb);
    while (!calm && $urandom_range(0, 99) < 32) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_cmd        <= c;
    in_write_byte <= wb;
    in_send_ack   <= ack;
    in_slave_bits <= sb;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    predict_line_run(c, wb, ack, sb);
    cmds_sent++;
  endtask

  task automatic drain_runs();
    in_valid <= 1'b0;
    while (pending_snaps.size() != 0) begin
      @(posedge clk);
    end
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(0, 99) < 32);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_snaps.size() == 0) begin
        report_mismatch("unexpected beat, last", out_last, 0);
      end else begin
        want = pending_snaps.pop_front();
        if (out_scl_level !== want.scl) report_mismatch("scl_level", out_scl_level, want.scl);
        if (out_sda_level !== want.sda) report_mismatch("sda_level", out_sda_level, want.sda);
        if (out_read_data !== want.rd) report_mismatch("read_data", out_read_data, want.rd);
        if (out_last !== want.fin) report_mismatch("last", out_last, want.fin);
      end
    end
  end

  initial begin
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_cmd        <= CMD_START;
    in_write_byte <= 8'h00;
    in_send_ack   <= 1'b0;
    in_slave_bits <= 8'h00;
    calm          <= 1'b0;
    cmds_sent     = 0;
    bus_scl       = 1'b1;
    bus_sda       = 1'b1;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[k]) begin
      send_cmd(dir_rows[k].cmd, dir_rows[k].wb, dir_rows[k].ack, dir_rows[k].sb);
      if (dir_rows[k].typed) begin
        pending_snaps[$].scl = dir_rows[k].scl;
        pending_snaps[$].sda = dir_rows[k].sda;
        pending_snaps[$].rd  = dir_rows[k].rd;
      end
    end
    drain_runs();

    while (cmds_sent < DIR_N + RAND_ITEMS) begin
      calm <= (cmds_sent >= DIR_N + 40) && (cmds_sent < DIR_N + 70);
      if (cmds_sent >= DIR_N + 20 && cmds_sent < DIR_N + 25) begin
        drain_runs();
      end
      if ($urandom_range(0, 3) == 0) begin
        send_cmd(cmd_t'($urandom_range(0, 3)), 8'($urandom), 1'($urandom), 8'($urandom));
      end else begin
        send_cmd(CMD_START, 8'($urandom), 1'($urandom), 8'($urandom));
        repeat ($urandom_range(1, 3)) begin
          send_cmd($urandom_range(0, 1) ? CMD_WRITE : CMD_READ,
                   8'($urandom), 1'($urandom), 8'($urandom));
        end
        send_cmd(CMD_STOP, 8'($urandom), 1'($urandom), 8'($urandom));
      end
    end

    calm <= 1'b0;
    drain_runs();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fails == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
